// File: rtl/dwc3_pkg.sv
// Package for the depthwise 3x3 stream: shared types, constants and the
// rounding/saturation function. No dependencies.
`default_nettype none
package dwc3_pkg;
  localparam int MaxWidth = 1024;
  localparam int ColBits = 10;
  localparam int SBits = 16;
  localparam int ProdBits = 32;
  localparam int AccBits = 36;

  typedef enum logic [2:0] {
    REG_WIDTH = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_W_TOP = 3'd2,
    REG_W_MID = 3'd3,
    REG_W_BOT = 3'd4
  } reg_idx_t;

  typedef logic signed [SBits-1:0] samp_t;

  // one queued job: a 3x3 patch plus tags
  typedef struct packed {
    samp_t [8:0] patch;   // index 3*row + col
    logic [15:0] row;
    logic [ColBits-1:0] col;
    logic frame_end;
    logic burst_end;
  } job_t;

  function automatic samp_t round_sat(input logic signed [AccBits-1:0] acc);
    logic signed [AccBits-1:0] t;
    logic signed [AccBits-13:0] q;
    begin
      t = acc + AccBits'(2048);
      q = t[AccBits-1:12];
      if (q > 32767) round_sat = 16'sh7fff;
      else if (q < -32768) round_sat = 16'sh8000;
      else round_sat = q[SBits-1:0];
    end
  endfunction
endpackage
`default_nettype wire

// File: rtl/depthwise_conv3x3_stream.sv
// Top level of the depthwise 3x3 stream: configuration registers, front and back.
// Depends on dwc3_pkg, dwc3_front, dwc3_back.
//
// channel   direction  handshake           payload
// input     in         push / full         sample
// result    out        pop / empty         result_value, result_row, result_col,
//                                          frame_end, burst_end
// config    in         cfg_we              cfg_index, cfg_data
//
// One sample per cycle while each sample yields at most one job and results drain;
// up to four results per sample, one per cycle while credit lasts, through one shared
// 9-tap multiply/sum pipeline. Synchronous reset clears counters, window and queues.
// A stalled result side fills the four-deep queue, then the job buffer, then full.
`default_nettype none
module depthwise_conv3x3_stream
  import dwc3_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic full,
  input  wire logic signed [15:0] sample,
  output logic empty,
  input  wire logic pop,
  output logic signed [15:0] result_value,
  output logic [15:0] result_row,
  output logic [9:0] result_col,
  output logic frame_end,
  output logic burst_end,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [47:0] cfg_data
);
  logic [10:0] image_width;
  logic [15:0] image_height;
  logic [47:0] w_top, w_mid, w_bot;
  logic job_valid, job_ready;
  job_t job;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 11'd1024;
      image_height <= 16'd1024;
      w_top <= '0;
      w_mid <= '0;
      w_bot <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  image_width <= cfg_data[10:0];
        REG_HEIGHT: image_height <= cfg_data[15:0];
        REG_W_TOP:  w_top <= cfg_data;
        REG_W_MID:  w_mid <= cfg_data;
        REG_W_BOT:  w_bot <= cfg_data;
        default: ;
      endcase
    end
  end

  dwc3_front u_front (
    .clk, .rst, .push, .full, .sample, .image_width, .image_height,
    .job_valid, .job_ready, .job
  );

  dwc3_back u_back (
    .clk, .rst, .job_valid, .job_ready, .job, .w_top, .w_mid, .w_bot,
    .empty, .pop, .result_value, .result_row, .result_col, .frame_end, .burst_end
  );

  a_fe_be: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_end) |-> burst_end) else $error("frame end without burst end");
  a_job_hold: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !job_ready) |=> job_valid) else $error("job dropped");
endmodule
`default_nettype wire

// File: rtl/dwc3_front.sv
// Front end: line stores, window, counters; issues up to four patch jobs per sample.
// Depends on dwc3_pkg.
`default_nettype none
module dwc3_front
  import dwc3_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic full,
  input  wire logic signed [15:0] sample,
  input  wire logic [10:0] image_width,
  input  wire logic [15:0] image_height,
  output logic job_valid,
  input  wire logic job_ready,
  output job_t job
);
  // stage 1: memory read, stage 2: job issue
  logic [15:0] mem0 [MaxWidth];
  logic [15:0] mem1 [MaxWidth];
  logic [15:0] rd0, rd1;
  logic [15:0] row_count, row_count_next;
  logic [ColBits-1:0] col_count, col_count_next;
  logic [10:0] w_eff;
  logic [15:0] h_eff;
  logic last_col, last_row;

  // stage-1 registers (item waiting for read data)
  logic s_valid;
  samp_t s_sample;
  logic [15:0] s_row;
  logic [ColBits-1:0] s_col;
  logic s_lastcol, s_lastrow;

  samp_t win [6];
  samp_t rr [3];
  samp_t ll [3];
  samp_t mm [3];
  logic [3:0] pend, pend_next;
  job_t jobs [4];
  logic [1:0] sel;
  logic busy, adv, take;
  logic [ColBits-1:0] c_in;

  always_comb begin
    w_eff = (image_width == 11'd0) ? 11'd1 :
            (image_width > 11'(MaxWidth)) ? 11'(MaxWidth) : image_width;
    h_eff = (image_height == 16'd0) ? 16'd1 : image_height;
    c_in = col_count;
    last_col = {1'b0, col_count} >= w_eff - 11'd1;
    last_row = row_count >= h_eff - 16'd1;
  end

  // stage-2 holds jobs until all issued
  assign busy = pend != 4'd0;
  assign adv = !busy || (pend_next == 4'd0);
  assign full = s_valid && !adv;
  assign take = push && !full;

  always_ff @(posedge clk) begin
    if (take) begin
      rd0 <= mem0[c_in];
      rd1 <= mem1[c_in];
      mem1[c_in] <= mem0[c_in];
      mem0[c_in] <= sample;
    end
  end

  always_comb begin
    row_count_next = row_count;
    col_count_next = col_count;
    if (take) begin
      if (last_col) begin
        col_count_next = '0;
        row_count_next = last_row ? 16'd0 : row_count + 16'd1;
      end else begin
        col_count_next = col_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      s_valid <= 1'b0;
    end else begin
      row_count <= row_count_next;
      col_count <= col_count_next;
      if (take) s_valid <= 1'b1;
      else if (adv) s_valid <= 1'b0;
    end
    if (take) begin
      s_sample <= sample;
      s_row <= row_count;
      s_col <= col_count;
      s_lastcol <= last_col;
      s_lastrow <= last_row;
    end
  end

  always_comb begin
    rr[0] = (s_row >= 16'd2) ? rd1 : '0;
    rr[1] = (s_row >= 16'd1) ? rd0 : '0;
    rr[2] = s_sample;
    for (int k = 0; k < 3; k++) begin
      mm[k] = (s_col != '0) ? win[k] : '0;
      ll[k] = (s_col != '0) ? win[3+k] : '0;
    end
  end

  always_comb begin
    pend_next = pend;
    if (job_valid && job_ready) pend_next[sel] = 1'b0;
  end

  always_comb begin
    sel = 2'd0;
    for (int i = 3; i >= 0; i--) if (pend[i]) sel = 2'(i);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      for (int i = 0; i < 6; i++) win[i] <= '0;
    end else if (s_valid && adv) begin
      for (int k = 0; k < 3; k++) begin
        win[3+k] <= mm[k];
        win[k] <= rr[k];
      end
      pend[0] <= (s_row >= 16'd1) && (s_col != '0);
      pend[1] <= (s_row >= 16'd1) && s_lastcol;
      pend[2] <= s_lastrow && (s_col != '0);
      pend[3] <= s_lastrow && s_lastcol;
    end else begin
      pend <= pend_next;
    end
    if (s_valid && adv) begin
      for (int k = 0; k < 3; k++) begin
        jobs[0].patch[3*k]   <= ll[k];
        jobs[0].patch[3*k+1] <= mm[k];
        jobs[0].patch[3*k+2] <= rr[k];
        jobs[1].patch[3*k]   <= mm[k];
        jobs[1].patch[3*k+1] <= rr[k];
        jobs[1].patch[3*k+2] <= '0;
      end
      for (int k = 0; k < 2; k++) begin
        jobs[2].patch[3*k]   <= ll[k+1];
        jobs[2].patch[3*k+1] <= mm[k+1];
        jobs[2].patch[3*k+2] <= rr[k+1];
        jobs[3].patch[3*k]   <= mm[k+1];
        jobs[3].patch[3*k+1] <= rr[k+1];
        jobs[3].patch[3*k+2] <= '0;
      end
      for (int j = 6; j < 9; j++) begin
        jobs[2].patch[j] <= '0;
        jobs[3].patch[j] <= '0;
      end
      jobs[0].row <= s_row - 16'd1;
      jobs[1].row <= s_row - 16'd1;
      jobs[2].row <= s_row;
      jobs[3].row <= s_row;
      jobs[0].col <= s_col - 1'b1;
      jobs[1].col <= s_col;
      jobs[2].col <= s_col - 1'b1;
      jobs[3].col <= s_col;
      jobs[0].frame_end <= 1'b0;
      jobs[1].frame_end <= 1'b0;
      jobs[2].frame_end <= 1'b0;
      jobs[3].frame_end <= 1'b1;
    end
  end

  always_comb begin
    job = jobs[sel];
    job.burst_end = (pend & ~(4'd1 << sel)) == 4'd0;
    job_valid = busy;
  end
endmodule
`default_nettype wire

// File: rtl/dwc3_back.sv
// Back end: multiply stage, sum/round stage and result queue.
// Depends on dwc3_pkg.
`default_nettype none
module dwc3_back
  import dwc3_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  output logic job_ready,
  input  wire job_t job,
  input  wire logic [47:0] w_top,
  input  wire logic [47:0] w_mid,
  input  wire logic [47:0] w_bot,
  output logic empty,
  input  wire logic pop,
  output logic signed [15:0] result_value,
  output logic [15:0] result_row,
  output logic [9:0] result_col,
  output logic frame_end,
  output logic burst_end
);
  localparam int QDepth = 4;
  // two stages ahead of the result queue; credits keep it from overflowing
  logic m_valid, a_valid;
  logic signed [ProdBits-1:0] prod [9];
  job_t m_job;
  logic signed [AccBits-1:0] acc;
  job_t a_job;
  samp_t a_val;
  logic [15:0] wts [9];

  logic [SBits+16+ColBits+1:0] q [QDepth];
  logic [1:0] wp, rp;
  logic [2:0] cnt, cnt_next;
  logic qpush, qpop;
  logic [2:0] inflight;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      wts[j]   = w_top[16*j +: 16];
      wts[3+j] = w_mid[16*j +: 16];
      wts[6+j] = w_bot[16*j +: 16];
    end
    inflight = cnt + {2'd0, m_valid} + {2'd0, a_valid};
    job_ready = inflight < 3'(QDepth);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      a_valid <= 1'b0;
    end else begin
      m_valid <= job_valid && job_ready;
      a_valid <= m_valid;
    end
    for (int i = 0; i < 9; i++) prod[i] <= job.patch[i] * $signed(wts[i]);
    m_job <= job;
    a_job <= m_job;
    a_val <= round_sat(acc);
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < 9; i++) acc = acc + AccBits'(prod[i]);
  end

  assign qpush = a_valid;
  assign qpop = pop && !empty;
  assign empty = cnt == 3'd0;

  always_comb begin
    cnt_next = cnt + {2'd0, qpush} - {2'd0, qpop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (qpush) wp <= wp + 2'd1;
      if (qpop) rp <= rp + 2'd1;
      cnt <= cnt_next;
    end
    if (qpush) q[wp] <= {a_val, a_job.row, a_job.col, a_job.frame_end, a_job.burst_end};
  end

  assign {result_value, result_row, result_col, frame_end, burst_end} = q[rp];
endmodule
`default_nettype wire

// File: verif/depthwise_conv3x3_stream_tb.sv
// Self-checking testbench for depthwise_conv3x3_stream: raster planes in,
// rounded 3x3 sums out, checked against an in-bench predictor.
// Depends on dwc3_pkg and the RTL of depthwise_conv3x3_stream.
`default_nettype none
module depthwise_conv3x3_stream_tb
  import dwc3_pkg::*;
;

  typedef struct packed {
    logic signed [15:0] value;
    logic [15:0] row;
    logic [9:0] col;
    logic fe;
    logic be;
  } conv_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic signed [15:0] sample = '0;
  logic pop = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic full, empty, frame_end, burst_end;
  logic signed [15:0] result_value;
  logic [15:0] result_row;
  logic [9:0] result_col;

  depthwise_conv3x3_stream u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .sample(sample),
    .empty(empty), .pop(pop), .result_value(result_value),
    .result_row(result_row), .result_col(result_col), .frame_end(frame_end),
    .burst_end(burst_end), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [10:0] p_width;
  logic [15:0] p_height;
  logic [47:0] p_wgt [3];
  logic signed [15:0] lines [2][MaxWidth];
  logic signed [15:0] win [6];
  logic [15:0] p_row;
  logic [9:0] p_col;

  logic signed [15:0] sample_q [$];
  conv_out_t expected_q [$];
  int errors = 0;
  int n_samples = 0;
  int n_results = 0;
  int hold_off = 0;

  function automatic logic signed [15:0] weigh(logic signed [15:0] p [9]);
    longint acc;
    longint q;
    acc = 0;
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++)
        acc += longint'(p[3*k+j]) * longint'($signed(p_wgt[k][16*j +: 16]));
    q = (acc + 2048) >>> 12;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  task automatic add_result(logic signed [15:0] a [3], logic signed [15:0] b [3],
                            logic signed [15:0] c [3], int r, int cl, bit fe);
    logic signed [15:0] p [9];
    conv_out_t e;
    for (int k = 0; k < 3; k++) begin
      p[3*k] = a[k];
      p[3*k+1] = b[k];
      p[3*k+2] = c[k];
    end
    e.value = weigh(p);
    e.row = r[15:0];
    e.col = cl[9:0];
    e.fe = fe;
    e.be = 1'b0;
    expected_q.push_back(e);
  endtask

  task automatic predict_sample(logic signed [15:0] s);
    int w, h, r, c, n0;
    logic signed [15:0] lft [3], mid [3], rgt [3], zro [3], a [3], b [3], c3 [3];
    bit lastcol, lastrow;
    w = p_width; h = p_height; r = p_row; c = p_col;
    if (w < 1) w = 1;
    if (w > MaxWidth) w = MaxWidth;
    if (h < 1) h = 1;
    n0 = expected_q.size();
    zro = '{default: '0};
    rgt[0] = (r >= 2) ? lines[1][c] : '0;
    rgt[1] = (r >= 1) ? lines[0][c] : '0;
    rgt[2] = s;
    lines[1][c] = lines[0][c];
    lines[0][c] = s;
    for (int k = 0; k < 3; k++) begin
      mid[k] = (c != 0) ? win[k] : '0;
      lft[k] = (c != 0) ? win[3+k] : '0;
    end
    for (int k = 0; k < 3; k++) begin
      win[3+k] = mid[k];
      win[k] = rgt[k];
    end
    lastcol = c >= w - 1;
    lastrow = r >= h - 1;
    if (r >= 1 && c >= 1) add_result(lft, mid, rgt, r - 1, c - 1, 1'b0);
    if (r >= 1 && lastcol) add_result(mid, rgt, zro, r - 1, c, 1'b0);
    if (lastrow) begin
      a = '{lft[1], lft[2], 16'sd0};
      b = '{mid[1], mid[2], 16'sd0};
      c3 = '{rgt[1], rgt[2], 16'sd0};
      if (c >= 1) add_result(a, b, c3, r, c - 1, 1'b0);
      if (lastcol) add_result(b, c3, zro, r, c, 1'b1);
    end
    if (expected_q.size() > n0) expected_q[$].be = 1'b1;
    if (lastcol) begin
      p_col = '0;
      p_row = lastrow ? '0 : p_row + 16'd1;
    end else begin
      p_col = p_col + 10'd1;
    end
  endtask

  // driver: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        predict_sample(sample);
        n_samples++;
        void'(sample_q.pop_front());
      end
      if (push && full) begin
        // request waits unchanged
      end else if (sample_q.size() == 0) begin
        push <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        sample <= sample_q[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        n_results++;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: row %0d col %0d", result_row, result_col);
          errors++;
        end else begin
          conv_out_t e;
          e = expected_q.pop_front();
          if (result_value !== e.value) begin
            $error("result_value: expected %0d actual %0d", e.value, result_value);
            errors++;
          end
          if (result_row !== e.row) begin
            $error("result_row: expected %0d actual %0d", e.row, result_row);
            errors++;
          end
          if (result_col !== e.col) begin
            $error("result_col: expected %0d actual %0d", e.col, result_col);
            errors++;
          end
          if (frame_end !== e.fe) begin
            $error("frame_end: expected %0d actual %0d", e.fe, frame_end);
            errors++;
          end
          if (burst_end !== e.be) begin
            $error("burst_end: expected %0d actual %0d", e.be, burst_end);
            errors++;
          end
        end
      end
      stall_phase <= (stall_phase + 1) % 37;
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        pop <= 1'b0;
      end else if (stall_phase < 12) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WIDTH: p_width = val[10:0];
      REG_HEIGHT: p_height = val[15:0];
      REG_W_TOP: p_wgt[0] = val;
      REG_W_MID: p_wgt[1] = val;
      default: p_wgt[2] = val;
    endcase
  endtask

  task automatic wait_idle();
    while (sample_q.size() > 0 || push || expected_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_weights(int mode);
    logic [47:0] v;
    for (int j = 0; j < 3; j++)
      case (mode)
        0: v[16*j +: 16] = 16'($urandom);
        1: v[16*j +: 16] = 16'h7fff;
        2: v[16*j +: 16] = 16'h8000;
        default: v[16*j +: 16] = 16'($urandom_range(0, 8191) - 4096);
      endcase
    return v;
  endfunction

  // one plane; full planes keep every line store read behind a write
  task automatic run_plane(int w, int h, logic [47:0] wt, logic [47:0] wm,
                           logic [47:0] wb, int mode);
    write_reg(REG_WIDTH, 48'(w));
    write_reg(REG_HEIGHT, 48'(h));
    write_reg(REG_W_TOP, wt);
    write_reg(REG_W_MID, wm);
    write_reg(REG_W_BOT, wb);
    for (int i = 0; i < ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h); i++)
      case (mode)
        0: sample_q.push_back(16'($urandom));
        1: sample_q.push_back(16'sh7fff);
        2: sample_q.push_back(16'sh8000);
        default: sample_q.push_back(16'($urandom_range(0, 2047) - 1024));
      endcase
    wait_idle();
  endtask

  initial begin
    p_width = 11'd1024;
    p_height = 16'd1024;
    p_wgt = '{default: '0};
    lines = '{default: '{default: '0}};
    win = '{default: '0};
    p_row = '0;
    p_col = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes of weights and samples, tiny and degenerate planes
    run_plane(3, 3, rand_weights(1), rand_weights(1), rand_weights(1), 1);
    run_plane(2, 2, rand_weights(2), rand_weights(2), rand_weights(2), 1);
    run_plane(0, 0, rand_weights(1), rand_weights(2), rand_weights(1), 2);
    run_plane(1, 4, rand_weights(0), rand_weights(0), rand_weights(0), 0);
    run_plane(4, 1, 48'h0, 48'h0000_1000_0000, 48'h0, 0);
    // long hold-off: block fills and stalls its input
    hold_off = 300;
    run_plane(8, 6, rand_weights(3), rand_weights(3), rand_weights(3), 0);
    // random small planes
    while (n_samples < 120) begin
      int w, h;
      w = $urandom_range(1, 9);
      h = $urandom_range(1, 7);
      run_plane(w, h, rand_weights($urandom_range(0, 3)), rand_weights($urandom_range(0, 3)),
                rand_weights($urandom_range(0, 3)), $urandom_range(0, 3));
    end
    $display("Covered %0d samples and %0d results over planes from 1x1 to 9 wide,",
             n_samples, n_results);
    $display("with saturating weights, stalls and a long receiver hold-off.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
rtl/dwc3_pkg.sv
rtl/dwc3_front.sv
rtl/dwc3_back.sv
rtl/depthwise_conv3x3_stream.sv
verif/depthwise_conv3x3_stream_tb.sv
